// File: sv/swtmr_pkg.sv
// Shared types and constants for the software timer expiry table.
// No dependencies; used by swtmr_us2tick and software_timer_expiry_table_unit.
package swtmr_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int SLOT_FIELD_W  = 4;
  localparam int DELAY_W       = 32;
  localparam int HANDLER_W     = 8;
  localparam int ARG_W         = 32;
  localparam int TICK_W        = 23;
  localparam int US_PER_TICK   = 1000;

  typedef enum logic [1:0] {
    FUNC_ARM    = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_TICK   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_UNLINK,
    ST_INS_START,
    ST_INSERT,
    ST_PLACE,
    ST_TICK,
    ST_FIRE,
    ST_ACK,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic [HANDLER_W-1:0] handler;
    logic [ARG_W-1:0]     argument;
  } slot_pay_t;

endpackage

// File: sv/swtmr_us2tick.sv
// Microsecond-to-tick converter: delay / 1000 via reciprocal multiply, zero clamped to one.
// Depends on swtmr_pkg. Registers the product, then the tick count; starts may overlap.
module swtmr_us2tick (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [swtmr_pkg::DELAY_W-1:0]     delay_us,
  output logic                              done,
  output logic [swtmr_pkg::TICK_W-1:0]      ticks
);

  // floor(x / 1000) == (x * ceil(2^38 / 1000)) >> 38 for every 32-bit x
  localparam int RECIP_SHIFT = 38;
  localparam int RECIP_W     = 29;
  localparam int PROD_W      = swtmr_pkg::DELAY_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(swtmr_pkg::US_PER_TICK) - 64'd1) /
    64'(swtmr_pkg::US_PER_TICK);
  localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_FULL[RECIP_W-1:0];

  logic                            prod_vld_r;
  logic [PROD_W-1:0]               prod_r;
  logic                            done_r;
  logic [swtmr_pkg::TICK_W-1:0]    ticks_r;
  logic [swtmr_pkg::TICK_W-1:0]    quot;

  assign quot = prod_r[RECIP_SHIFT +: swtmr_pkg::TICK_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      prod_vld_r <= start;
      done_r     <= prod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= delay_us * RECIP_MULT;
    end
    if (prod_vld_r) begin
      ticks_r <= (quot == '0) ? swtmr_pkg::TICK_W'(1) : quot;
    end
  end

  assign done  = done_r;
  assign ticks = ticks_r;

endmodule

// File: sv/software_timer_expiry_table_unit.sv
// Top level of the software timer expiry table: sequencer, ordered expiry list and slot store.
// Depends on swtmr_pkg and swtmr_us2tick.
//
// Usage: one input channel (in_valid/in_ready) carries arm, cancel and tick transactions;
// one result channel (out_valid/out_ready) returns results through an output register.
// Arm and cancel give one acknowledge transaction. A tick gives one transaction per
// expired timer, in expiry order, with out_last_result on the final one, or a single
// no-expiry transaction. The expiry list (slot, remaining ticks) lives in a
// one-port-read, one-port-write memory with a registered read; handler and argument
// live in a second such memory indexed by slot.
// Steps: a tick walks the list once, counting each entry down and reporting each expiry
// as it is found. Arm divides the delay by 1000, unlinks the old entry when re-arming,
// shifts each entry behind the insert point back, places the new entry and acknowledges.
// Cancel unlinks the entry when the slot is armed, then acknowledges.
// in_ready is high only while the sequencer is idle; a result waiting in the output
// register does not hold off the next input, but the walk stalls when it needs the
// output register and the receiver has not taken the previous result.
// Reset clears all slots to unarmed and empties the list; no clearing pass is needed.
module software_timer_expiry_table_unit #(
  parameter int NUM_SLOTS = swtmr_pkg::NUM_SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_func,
  input  logic [swtmr_pkg::SLOT_FIELD_W-1:0]   in_slot,
  input  logic [swtmr_pkg::DELAY_W-1:0]        in_delay_us,
  input  logic [swtmr_pkg::HANDLER_W-1:0]      in_handler_id,
  input  logic [swtmr_pkg::ARG_W-1:0]          in_argument,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_result_kind,
  output logic [swtmr_pkg::SLOT_FIELD_W-1:0]   out_fired_slot,
  output logic [swtmr_pkg::HANDLER_W-1:0]      out_fired_handler,
  output logic [swtmr_pkg::ARG_W-1:0]          out_fired_argument,
  output logic                                 out_last_result
);

  localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  typedef struct packed {
    logic [SW-1:0]                  slot;
    logic [swtmr_pkg::TICK_W-1:0]   ticks;
  } ord_ent_t;

  // Sequencer and list bookkeeping
  swtmr_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;        // armed timers in the list
  logic [CNT_W-1:0]     idx_r, idx_nxt;        // read position of the walk
  logic [CNT_W-1:0]     wr_r, wr_nxt;          // write position of the walk
  logic                 fired_r, fired_nxt;    // current tick has expired a timer
  logic [NUM_SLOTS-1:0] active_r, active_nxt;
  logic [SW-1:0]        fire_slot_r, fire_slot_nxt;

  // Captured input transaction
  logic [1:0]                          func_r;
  logic [swtmr_pkg::SLOT_FIELD_W-1:0]  slot_r;
  logic [swtmr_pkg::HANDLER_W-1:0]     handler_r;
  logic [swtmr_pkg::ARG_W-1:0]         arg_r;

  // Output register
  logic                                out_valid_r, out_valid_nxt;
  swtmr_pkg::kind_t                    out_kind_r, out_kind_nxt;
  logic [swtmr_pkg::SLOT_FIELD_W-1:0]  out_slot_r, out_slot_nxt;
  logic [swtmr_pkg::HANDLER_W-1:0]     out_handler_r, out_handler_nxt;
  logic [swtmr_pkg::ARG_W-1:0]         out_arg_r, out_arg_nxt;
  logic                                out_last_r, out_last_nxt;

  // Expiry list memory
  ord_ent_t             ord_mem [NUM_SLOTS];
  ord_ent_t             ord_q_r;
  logic                 ord_re, ord_we;
  logic [SW-1:0]        ord_raddr, ord_waddr;
  ord_ent_t             ord_wdata;

  // Slot payload memory
  swtmr_pkg::slot_pay_t slot_mem [NUM_SLOTS];
  swtmr_pkg::slot_pay_t slot_q_r;
  logic                 slot_re, slot_we;
  logic [SW-1:0]        slot_raddr;

  // Converter
  logic                                conv_start, conv_done;
  logic [swtmr_pkg::TICK_W-1:0]        conv_ticks;

  // Helpers
  logic                 in_acc, in_slot_ok, out_space, more, next_fires;
  logic [SW-1:0]        in_idx, slot_idx;
  logic [CNT_W-1:0]     idx_inc;
  ord_ent_t             new_ent;

  swtmr_us2tick u_us2tick (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (conv_start),
    .delay_us (in_delay_us),
    .done     (conv_done),
    .ticks    (conv_ticks)
  );

  assign in_ready   = (state_r == swtmr_pkg::ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign in_idx     = SW'(in_slot);
  assign in_slot_ok = int'(in_slot) < NUM_SLOTS;
  assign slot_idx   = SW'(slot_r);
  assign out_space  = !out_valid_r || out_ready;
  assign idx_inc    = idx_r + 1'b1;
  assign more       = idx_inc < cnt_r;
  assign next_fires = (idx_r < cnt_r) && (ord_q_r.ticks == swtmr_pkg::TICK_W'(1));
  assign new_ent    = '{slot: slot_idx, ticks: conv_ticks};

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r    <= in_func;
      slot_r    <= in_slot;
      handler_r <= in_handler_id;
      arg_r     <= in_argument;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swtmr_pkg::ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      wr_r        <= '0;
      fired_r     <= 1'b0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      wr_r        <= wr_nxt;
      fired_r     <= fired_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fire_slot_r   <= fire_slot_nxt;
    out_kind_r    <= out_kind_nxt;
    out_slot_r    <= out_slot_nxt;
    out_handler_r <= out_handler_nxt;
    out_arg_r     <= out_arg_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord_q_r <= ord_mem[ord_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_idx] <= '{handler: handler_r, argument: arg_r};
    end
    if (slot_re) begin
      slot_q_r <= slot_mem[slot_raddr];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    wr_nxt          = wr_r;
    fired_nxt       = fired_r;
    active_nxt      = active_r;
    fire_slot_nxt   = fire_slot_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_slot_nxt    = out_slot_r;
    out_handler_nxt = out_handler_r;
    out_arg_nxt     = out_arg_r;
    out_last_nxt    = out_last_r;
    ord_re          = 1'b0;
    ord_raddr       = idx_inc[SW-1:0];
    ord_we          = 1'b0;
    ord_waddr       = wr_r[SW-1:0];
    ord_wdata       = ord_q_r;
    slot_re         = 1'b0;
    slot_raddr      = ord_q_r.slot;
    slot_we         = 1'b0;
    conv_start      = 1'b0;

    case (state_r)
      swtmr_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_nxt   = '0;
          wr_nxt    = '0;
          fired_nxt = 1'b0;
          ord_raddr = '0;
          case (in_func)
            swtmr_pkg::FUNC_TICK: begin
              if (cnt_r == '0) begin
                state_nxt = swtmr_pkg::ST_EMPTY;
              end else begin
                ord_re    = 1'b1;
                state_nxt = swtmr_pkg::ST_TICK;
              end
            end
            swtmr_pkg::FUNC_ARM: begin
              if (in_slot_ok) begin
                conv_start = 1'b1;
                state_nxt  = swtmr_pkg::ST_CONV;
              end else begin
                state_nxt = swtmr_pkg::ST_ACK;
              end
            end
            swtmr_pkg::FUNC_CANCEL: begin
              if (in_slot_ok && active_r[in_idx]) begin
                ord_re    = 1'b1;
                state_nxt = swtmr_pkg::ST_UNLINK;
              end else begin
                state_nxt = swtmr_pkg::ST_ACK;
              end
            end
            default: begin
              state_nxt = swtmr_pkg::ST_ACK;
            end
          endcase
        end
      end

      // Wait for the tick count; drop the old entry first when re-arming
      swtmr_pkg::ST_CONV: begin
        if (conv_done) begin
          if (active_r[slot_idx]) begin
            ord_re    = 1'b1;
            ord_raddr = '0;
            state_nxt = swtmr_pkg::ST_UNLINK;
          end else begin
            state_nxt = swtmr_pkg::ST_INS_START;
          end
        end
      end

      // Compact the list forward, skipping the entry of slot_r
      swtmr_pkg::ST_UNLINK: begin
        if (ord_q_r.slot != slot_idx) begin
          ord_we = 1'b1;
          wr_nxt = wr_r + 1'b1;
        end
        if (more) begin
          ord_re  = 1'b1;
          idx_nxt = idx_inc;
        end else begin
          cnt_nxt              = wr_nxt;
          active_nxt[slot_idx] = 1'b0;
          state_nxt = (func_r == swtmr_pkg::FUNC_ARM) ? swtmr_pkg::ST_INS_START
                                                      : swtmr_pkg::ST_ACK;
        end
      end

      // Start the backward shift from the tail of the list
      swtmr_pkg::ST_INS_START: begin
        if (int'(cnt_r) >= NUM_SLOTS) begin
          state_nxt = swtmr_pkg::ST_ACK;
        end else if (cnt_r == '0) begin
          idx_nxt   = '0;
          state_nxt = swtmr_pkg::ST_PLACE;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = SW'(cnt_r - 1'b1);
          idx_nxt   = cnt_r;
          state_nxt = swtmr_pkg::ST_INSERT;
        end
      end

      // ord_q_r holds entry idx_r-1; move it up while it expires strictly later
      swtmr_pkg::ST_INSERT: begin
        ord_we    = 1'b1;
        ord_waddr = idx_r[SW-1:0];
        if (ord_q_r.ticks > conv_ticks) begin
          idx_nxt = idx_r - 1'b1;
          if (idx_r > CNT_W'(1)) begin
            ord_re    = 1'b1;
            ord_raddr = SW'(idx_r - CNT_W'(2));
          end else begin
            state_nxt = swtmr_pkg::ST_PLACE;
          end
        end else begin
          ord_wdata            = new_ent;
          slot_we              = 1'b1;
          active_nxt[slot_idx] = 1'b1;
          cnt_nxt              = cnt_r + 1'b1;
          state_nxt            = swtmr_pkg::ST_ACK;
        end
      end

      swtmr_pkg::ST_PLACE: begin
        ord_we               = 1'b1;
        ord_waddr            = idx_r[SW-1:0];
        ord_wdata            = new_ent;
        slot_we              = 1'b1;
        active_nxt[slot_idx] = 1'b1;
        cnt_nxt              = cnt_r + 1'b1;
        state_nxt            = swtmr_pkg::ST_ACK;
      end

      // ord_q_r holds entry idx_r; count it down, expire or write it back compacted
      swtmr_pkg::ST_TICK: begin
        if (ord_q_r.ticks == swtmr_pkg::TICK_W'(1)) begin
          slot_re                  = 1'b1;
          active_nxt[ord_q_r.slot] = 1'b0;
          fired_nxt                = 1'b1;
          fire_slot_nxt            = ord_q_r.slot;
          idx_nxt                  = idx_inc;
          ord_re                   = more;
          state_nxt                = swtmr_pkg::ST_FIRE;
        end else begin
          ord_we          = 1'b1;
          ord_wdata.ticks = ord_q_r.ticks - 1'b1;
          wr_nxt          = wr_r + 1'b1;
          if (more) begin
            ord_re  = 1'b1;
            idx_nxt = idx_inc;
          end else begin
            cnt_nxt   = wr_r + 1'b1;
            state_nxt = fired_r ? swtmr_pkg::ST_IDLE : swtmr_pkg::ST_EMPTY;
          end
        end
      end

      // Report one expired timer; ord_q_r already holds the next entry
      swtmr_pkg::ST_FIRE: begin
        if (out_space) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = swtmr_pkg::KIND_FIRED;
          out_slot_nxt    = swtmr_pkg::SLOT_FIELD_W'(fire_slot_r);
          out_handler_nxt = slot_q_r.handler;
          out_arg_nxt     = slot_q_r.argument;
          out_last_nxt    = !next_fires;
          if (idx_r < cnt_r) begin
            state_nxt = swtmr_pkg::ST_TICK;
          end else begin
            cnt_nxt   = wr_r;
            state_nxt = swtmr_pkg::ST_IDLE;
          end
        end
      end

      swtmr_pkg::ST_ACK: begin
        if (out_space) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = swtmr_pkg::KIND_ACK;
          out_slot_nxt    = slot_r;
          out_handler_nxt = '0;
          out_arg_nxt     = '0;
          out_last_nxt    = 1'b1;
          state_nxt       = swtmr_pkg::ST_IDLE;
        end
      end

      swtmr_pkg::ST_EMPTY: begin
        if (out_space) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = swtmr_pkg::KIND_EMPTY;
          out_slot_nxt    = '0;
          out_handler_nxt = '0;
          out_arg_nxt     = '0;
          out_last_nxt    = 1'b1;
          state_nxt       = swtmr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = swtmr_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_fired_slot     = out_slot_r;
  assign out_fired_handler  = out_handler_r;
  assign out_fired_argument = out_arg_r;
  assign out_last_result    = out_last_r;

  // The list never holds more entries than there are slots
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= NUM_SLOTS)
    else $error("armed count exceeds slot count");

  // Between transactions the list length matches the armed slots
  a_cnt_active: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == swtmr_pkg::ST_IDLE |-> $countones(active_r) == int'(cnt_r))
    else $error("armed count out of step with active slots");

  // The walk never reads and writes the same list entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    ord_re && ord_we |-> ord_raddr != ord_waddr)
    else $error("expiry list read and write collide");

  // The tick walk only looks at entries inside the list
  a_tick_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == swtmr_pkg::ST_TICK |-> idx_r < cnt_r)
    else $error("tick walk past end of list");

endmodule
